// File: src/assert_macros.svh
// Assertion helpers used by the replacer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/wwtr_pkg.sv
package wwtr_pkg;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SH1,
        CELL_SH2,
        CELL_SHL,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [7:0]  load_byte;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        REG_TOKEN,
        REG_TOKEN_LEN,
        REG_REPL,
        REG_REPL_LEN
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] token;
        logic [3:0]  token_len;
        logic [63:0] repl;
        logic [3:0]  repl_len;
    } cfg_t;

    function automatic logic is_word(input logic [7:0] b);
        return (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UZ) ||
               (b >= CH_LA && b <= CH_LZ) || (b == CH_USCORE);
    endfunction

endpackage

// File: src/whole_word_token_replacer_core.sv
// Whole-word token replacer. Bytes stream in with in_last on the final byte of
// a text; each whole-word token outside string literals and // comments comes
// out as the replacement. Unless the output stalls, pass-through bytes move at
// one per cycle: a row of window cells compares the token in parallel and one
// decision is taken per cycle. A replacement or a // opener holds the input
// until its bytes are out. After in_last the window drains at one decision
// per cycle while output accepts, then releases the final byte. token_length
// is sampled at each text's first byte; output lags by up to that many bytes.
module whole_word_token_replacer_core import wwtr_pkg::*;
#(
    parameter int MAX_TOKEN_BYTES   = 8,
    parameter int MAX_REPLACE_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last
);

`include "assert_macros.svh"

    localparam int D  = MAX_TOKEN_BYTES + 1;
    localparam int FW = $clog2(MAX_TOKEN_BYTES + 2);
    localparam int IW = (MAX_REPLACE_BYTES > 1) ? $clog2(MAX_REPLACE_BYTES) : 1;

    cfg_t cfg;

    wwtr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // control state
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] act_len_reg, act_len_next;
    logic          open_reg, open_next;
    logic          flush_reg, flush_next;
    logic          prior_reg, prior_next;
    logic          lit_reg, lit_next;
    logic          esc_reg, esc_next;
    logic          cmt_reg, cmt_next;
    logic          slash_reg, slash_next;
    logic [3:0]    rem_reg, rem_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hv_reg, hv_next;
    logic [7:0]    hold_reg, hold_next;
    logic          out_v_reg, out_v_next;
    logic [7:0]    out_b_reg, out_b_next;
    logic          out_l_reg, out_l_next;

    // window cells
    cell_ctrl_t ctrl [D];
    logic [7:0] win [D];
    logic [7:0] nbl [D];
    logic       eq [D];
    logic       wd [D];

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic [7:0] n1, n2, tk;
        if (i + 1 < D)
        begin : g_n1
            assign n1 = win[i+1];
        end
        else
        begin : g_n1z
            assign n1 = 8'h00;
        end
        if (i + 2 < D)
        begin : g_n2
            assign n2 = win[i+2];
        end
        else
        begin : g_n2z
            assign n2 = 8'h00;
        end
        if (i < MAX_TOKEN_BYTES)
        begin : g_tk
            assign tk = cfg.token[8*i +: 8];
        end
        else
        begin : g_tkz
            assign tk = 8'h00;
        end
        wwtr_cell u_cell (
            .clk  (clk),
            .ctrl (ctrl[i]),
            .nb1  (n1),
            .nb2  (n2),
            .nbl  (nbl[i]),
            .tok  (tk),
            .q    (win[i]),
            .eq   (eq[i]),
            .word (wd[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            nbl[i] = 8'h00;
            for (int j = 1; j <= MAX_TOKEN_BYTES; j++)
            begin
                if (i + j < D && act_len_reg == FW'(j))
                    nbl[i] = win[(i + j) % D];
            end
        end
    end

    // decision on the head of the window
    logic          tok_match, word_at_len, word_last;
    logic          hit;
    logic [FW-1:0] eff_len;
    logic [3:0]    rl;
    logic          out_free, busy, need_dec, can_gen, dec_fire, finish, ins;
    logic          gen_has;
    logic [7:0]    gen_byte;
    cell_op_t      shift_op;
    logic [FW-1:0] kdec, pos;

    assign eff_len = open_reg ? act_len_reg :
                     (cfg.token_len > 4'(MAX_TOKEN_BYTES)) ? FW'(MAX_TOKEN_BYTES)
                                                            : FW'(cfg.token_len);
    assign rl = (cfg.repl_len > 4'(MAX_REPLACE_BYTES)) ? 4'(MAX_REPLACE_BYTES)
                                                        : cfg.repl_len;

    always_comb
    begin
        tok_match   = 1'b1;
        word_at_len = 1'b0;
        word_last   = 1'b0;
        for (int i = 0; i < MAX_TOKEN_BYTES; i++)
        begin
            if (FW'(i) < act_len_reg && !eq[i])
                tok_match = 1'b0;
            if (FW'(i + 1) == act_len_reg)
            begin
                word_last   = wd[i];
                word_at_len = wd[i+1];
            end
        end
    end

    assign hit = !cmt_reg && !lit_reg && act_len_reg != '0 && fill_reg >= act_len_reg &&
                 !prior_reg && tok_match &&
                 ((fill_reg == act_len_reg) ? flush_reg : !word_at_len);

    assign out_free = !out_v_reg || out_ready;
    assign busy     = (rem_reg != 4'd0) || slash_reg;
    assign need_dec = flush_reg ? (fill_reg != '0) : (fill_reg > act_len_reg);
    assign can_gen  = flush_reg ? (!hv_reg || out_free) : out_free;
    assign dec_fire = !busy && need_dec && can_gen;
    assign finish   = flush_reg && fill_reg == '0 && !busy && (!hv_reg || out_free);

    assign in_ready = flush_reg ? 1'b0 :
                      (eff_len == '0) ? out_free :
                      (!busy && (!need_dec || dec_fire));
    assign ins = in_valid && in_ready && eff_len != '0;

    always_comb
    begin
        gen_has    = 1'b0;
        gen_byte   = win[0];
        shift_op   = CELL_HOLD;
        kdec       = '0;
        prior_next = prior_reg;
        lit_next   = lit_reg;
        esc_next   = esc_reg;
        cmt_next   = cmt_reg;
        slash_next = slash_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;

        if (busy && can_gen)
        begin
            gen_has = 1'b1;
            if (slash_reg)
            begin
                gen_byte   = CH_SLASH;
                slash_next = 1'b0;
            end
            else
            begin
                gen_byte = cfg.repl[8*idx_reg +: 8];
                rem_next = rem_reg - 4'd1;
                idx_next = idx_reg + IW'(1);
            end
        end
        else if (dec_fire)
        begin
            if (hit)
            begin
                shift_op   = CELL_SHL;
                kdec       = act_len_reg;
                prior_next = word_last;
                if (rl != 4'd0)
                begin
                    gen_has  = 1'b1;
                    gen_byte = cfg.repl[7:0];
                    rem_next = rl - 4'd1;
                    idx_next = IW'(1);
                end
            end
            else
            begin
                gen_has    = 1'b1;
                prior_next = wd[0];
                shift_op   = CELL_SH1;
                kdec       = FW'(1);
                if (cmt_reg)
                begin
                    if (win[0] == CH_NL)
                        cmt_next = 1'b0;
                end
                else if (lit_reg)
                begin
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (win[0] == CH_BSL)
                        esc_next = 1'b1;
                    else if (win[0] == CH_DQ)
                        lit_next = 1'b0;
                end
                else if (win[0] == CH_DQ)
                begin
                    lit_next = 1'b1;
                end
                else if (win[0] == CH_SLASH && fill_reg >= FW'(2) && win[1] == CH_SLASH)
                begin
                    slash_next = 1'b1;
                    prior_next = 1'b0;
                    cmt_next   = 1'b1;
                    shift_op   = CELL_SH2;
                    kdec       = FW'(2);
                end
            end
        end
    end

    assign pos = fill_reg - kdec;

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            ctrl[i].load_byte = in_byte;
            if (ins && FW'(i) == pos)
                ctrl[i].op = CELL_LOAD;
            else
                ctrl[i].op = shift_op;
        end
    end

    // text state, hold stage and output register
    always_comb
    begin
        fill_next    = fill_reg - kdec + (ins ? FW'(1) : FW'(0));
        act_len_next = act_len_reg;
        open_next    = open_reg;
        flush_next   = flush_reg;
        hv_next      = hv_reg;
        hold_next    = hold_reg;
        out_v_next   = out_v_reg && !out_ready;
        out_b_next   = out_b_reg;
        out_l_next   = out_l_reg;

        if (in_valid && in_ready)
        begin
            open_next    = 1'b1;
            act_len_next = eff_len;
            if (eff_len == '0)
            begin
                out_v_next = 1'b1;
                out_b_next = in_byte;
                out_l_next = in_last;
                if (in_last)
                    open_next = 1'b0;
            end
            else if (in_last)
            begin
                flush_next = 1'b1;
            end
        end

        if (gen_has)
        begin
            if (!flush_reg)
            begin
                out_v_next = 1'b1;
                out_b_next = gen_byte;
                out_l_next = 1'b0;
            end
            else
            begin
                // final text: keep one byte back so the last one can be tagged
                if (hv_reg)
                begin
                    out_v_next = 1'b1;
                    out_b_next = hold_reg;
                    out_l_next = 1'b0;
                end
                hv_next   = 1'b1;
                hold_next = gen_byte;
            end
        end

        if (finish)
        begin
            if (hv_reg)
            begin
                out_v_next = 1'b1;
                out_b_next = hold_reg;
                out_l_next = 1'b1;
            end
            hv_next      = 1'b0;
            flush_next   = 1'b0;
            open_next    = 1'b0;
            act_len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            act_len_reg <= '0;
            open_reg    <= 1'b0;
            flush_reg   <= 1'b0;
            prior_reg   <= 1'b0;
            lit_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            cmt_reg     <= 1'b0;
            slash_reg   <= 1'b0;
            rem_reg     <= 4'd0;
            idx_reg     <= '0;
            hv_reg      <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else if (finish)
        begin
            fill_reg    <= '0;
            act_len_reg <= act_len_next;
            open_reg    <= open_next;
            flush_reg   <= flush_next;
            prior_reg   <= 1'b0;
            lit_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            cmt_reg     <= 1'b0;
            slash_reg   <= 1'b0;
            rem_reg     <= 4'd0;
            idx_reg     <= '0;
            hv_reg      <= hv_next;
            out_v_reg   <= out_v_next;
        end
        else
        begin
            fill_reg    <= fill_next;
            act_len_reg <= act_len_next;
            open_reg    <= open_next;
            flush_reg   <= flush_next;
            prior_reg   <= prior_next;
            lit_reg     <= lit_next;
            esc_reg     <= esc_next;
            cmt_reg     <= cmt_next;
            slash_reg   <= slash_next;
            rem_reg     <= rem_next;
            idx_reg     <= idx_next;
            hv_reg      <= hv_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        out_b_reg <= out_b_next;
        out_l_reg <= out_l_next;
    end

    assign out_valid = out_v_reg;
    assign out_byte  = out_b_reg;
    assign out_last  = out_l_reg;

    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= FW'(D))
    `ASSERT_IMPLY(a_no_input_in_flush, clk, rst_n, flush_reg, !in_ready)
    `ASSERT_IMPLY(a_hold_only_in_flush, clk, rst_n, hv_reg, flush_reg)
    `ASSERT_IMPLY(a_fill_within_len, clk, rst_n, !flush_reg && !busy,
                  fill_reg <= act_len_reg + FW'(1))

endmodule

// File: src/wwtr_cell.sv
module wwtr_cell import wwtr_pkg::*;
(
    input  logic        clk,
    input  cell_ctrl_t  ctrl,
    input  logic [7:0]  nb1,
    input  logic [7:0]  nb2,
    input  logic [7:0]  nbl,
    input  logic [7:0]  tok,
    output logic [7:0]  q,
    output logic        eq,
    output logic        word
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_SH1:  byte_next = nb1;
            CELL_SH2:  byte_next = nb2;
            CELL_SHL:  byte_next = nbl;
            CELL_LOAD: byte_next = ctrl.load_byte;
            default:   byte_next = byte_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q    = byte_reg;
    assign eq   = (byte_reg == tok);
    assign word = is_word(byte_reg);

endmodule

// File: src/wwtr_regs.sv
module wwtr_regs import wwtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_TOKEN:     cfg_reg.token     <= pwdata;
                REG_TOKEN_LEN: cfg_reg.token_len <= pwdata[3:0];
                REG_REPL:      cfg_reg.repl      <= pwdata;
                REG_REPL_LEN:  cfg_reg.repl_len  <= pwdata[3:0];
                default:       cfg_reg.token     <= cfg_reg.token;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TOKEN:     prdata = cfg_reg.token;
            REG_TOKEN_LEN: prdata = {60'd0, cfg_reg.token_len};
            REG_REPL:      prdata = cfg_reg.repl;
            REG_REPL_LEN:  prdata = {60'd0, cfg_reg.repl_len};
            default:       prdata = '0;
        endcase
    end

endmodule
